// File: rtl/drsqrt_pkg.sv
// Package for the digit-recurrence square root: widths, control types, state codes.
`default_nettype none
package drsqrt_pkg;

   localparam int RADICAND_WIDTH  = 32;
   localparam int MAX_EXTRA_STEPS = 15;
   localparam int SETTING_WIDTH   = 5;
   localparam int ROOT_WIDTH      = 31;

   // radicand is zero-padded to a whole number of bit pairs
   localparam int DIGIT_PAIRS   = (RADICAND_WIDTH + 1) / 2;
   localparam int RAD_PAD_WIDTH = 2 * DIGIT_PAIRS;
   localparam int ROOT_FULL_W   = DIGIT_PAIRS + MAX_EXTRA_STEPS;
   localparam int ROOT_REG_W    = (ROOT_FULL_W > ROOT_WIDTH) ? ROOT_FULL_W : ROOT_WIDTH;
   // partial remainder never exceeds twice the root, plus the two new bits
   localparam int REM_WIDTH     = ROOT_REG_W + 2;
   localparam int K_WIDTH       = (MAX_EXTRA_STEPS > 0) ? $clog2(MAX_EXTRA_STEPS + 1) : 1;
   localparam int HALF_WIDTH    = SETTING_WIDTH - 1;
   localparam int CNT_WIDTH     = $clog2(ROOT_FULL_W + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } drsqrt_state_type;

   typedef struct packed {
      logic load;     // take a new word into the datapath
      logic step;     // perform one root-bit step
      logic publish;  // move the finished root into the output register
   } drsqrt_ctrl_type;

endpackage
`default_nettype wire

// File: rtl/digit_recurrence_square_root.sv
// Top level of the restoring digit-recurrence integer square root.
// Each word: load, 16 + k root-bit steps, publish to rsp_valid; k = min(setting/2, 15).
// The next word waits until the root is published, due to the single shared root-bit step
// (one compare and subtract on the partial remainder each cycle).
// A finished root waits in its own output register, so the next word may be taken meanwhile.
// Reset (synchronous, active high) returns the sequencer to idle and drops rsp_valid.
`default_nettype none
module digit_recurrence_square_root (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // request channel
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic [drsqrt_pkg::RADICAND_WIDTH-1:0]  req_radicand,
   input  wire logic [drsqrt_pkg::SETTING_WIDTH-1:0]   req_iteration_setting,
   // response channel
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic [drsqrt_pkg::ROOT_WIDTH-1:0]           rsp_root
);
   import drsqrt_pkg::*;

   drsqrt_ctrl_type ctrl;

   // Sequencer: loads the word, counts 16 + k steps, then hands the root to the
   // output register once that register is free.
   drsqrt_ctrl u_ctrl (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_iteration_setting (req_iteration_setting),
      .req_stall             (req_stall),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .ctrl                  (ctrl)
   );

   // Datapath: two radicand bits come down per step and one root bit goes up.
   // After the radicand pairs run out the shifter feeds zero pairs, which gives
   // the extra fractional root bits.
   drsqrt_datapath u_datapath (
      .clock        (clock),
      .ctrl         (ctrl),
      .req_radicand (req_radicand),
      .rsp_root     (rsp_root)
   );

endmodule
`default_nettype wire

// File: rtl/drsqrt_ctrl.sv
// Sequencer for the square root: step counter, state machine and result valid flag.
`default_nettype none
module drsqrt_ctrl (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   input  wire logic [drsqrt_pkg::SETTING_WIDTH-1:0]  req_iteration_setting,
   output logic                                       req_stall,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output drsqrt_pkg::drsqrt_ctrl_type                ctrl
);
   import drsqrt_pkg::*;

   drsqrt_state_type       state_ff, state_in;
   logic [CNT_WIDTH-1:0]   steps_left_ff, steps_left_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [HALF_WIDTH-1:0]  half_setting;
   logic [K_WIDTH-1:0]     extra_steps;
   logic                   accept;
   logic                   out_free;

   // odd settings drop their low bit; saturate at the extra-step limit
   assign half_setting = req_iteration_setting[SETTING_WIDTH-1:1];
   assign extra_steps  = (32'(half_setting) > 32'(MAX_EXTRA_STEPS))
                         ? K_WIDTH'(MAX_EXTRA_STEPS) : K_WIDTH'(half_setting);

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      steps_left_in = steps_left_ff;
      ctrl          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ctrl.load     = 1'b1;
               steps_left_in = CNT_WIDTH'(DIGIT_PAIRS) + CNT_WIDTH'(extra_steps);
               state_in      = ST_RUN;
            end
         end
         ST_RUN: begin
            ctrl.step     = 1'b1;
            steps_left_in = steps_left_ff - CNT_WIDTH'(1);
            if (steps_left_ff == CNT_WIDTH'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               ctrl.publish = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = ctrl.publish || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         steps_left_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         steps_left_ff <= steps_left_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/drsqrt_datapath.sv
// Digit-serial datapath: radicand pair shifter, partial remainder, root shifter, output word.
`default_nettype none
module drsqrt_datapath (
   input  wire logic                                   clock,
   input  wire drsqrt_pkg::drsqrt_ctrl_type            ctrl,
   input  wire logic [drsqrt_pkg::RADICAND_WIDTH-1:0]  req_radicand,
   output logic [drsqrt_pkg::ROOT_WIDTH-1:0]           rsp_root
);
   import drsqrt_pkg::*;

   logic [RAD_PAD_WIDTH-1:0] rad_ff, rad_in;
   logic [REM_WIDTH-1:0]     rem_ff, rem_in;
   logic [ROOT_REG_W-1:0]    root_ff, root_in;
   logic [ROOT_WIDTH-1:0]    out_root_ff, out_root_in;
   logic [REM_WIDTH-1:0]     rem_shift;
   logic [REM_WIDTH-1:0]     trial;
   logic [REM_WIDTH-1:0]     diff;
   logic                     fits;

   // top pair of the radicand comes down each step; zeros follow for the extra steps
   assign rem_shift = {rem_ff[REM_WIDTH-3:0], rad_ff[RAD_PAD_WIDTH-1 -: 2]};
   assign trial     = {root_ff, 2'b01};
   assign diff      = rem_shift - trial;
   assign fits      = (rem_shift >= trial);

   always_comb begin
      rad_in      = rad_ff;
      rem_in      = rem_ff;
      root_in     = root_ff;
      out_root_in = out_root_ff;
      if (ctrl.load) begin
         rad_in  = RAD_PAD_WIDTH'(req_radicand);
         rem_in  = '0;
         root_in = '0;
      end else if (ctrl.step) begin
         rad_in  = {rad_ff[RAD_PAD_WIDTH-3:0], 2'b00};
         rem_in  = fits ? diff : rem_shift;
         root_in = {root_ff[ROOT_REG_W-2:0], fits};
      end
      if (ctrl.publish) begin
         out_root_in = root_ff[ROOT_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      rad_ff      <= rad_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      out_root_ff <= out_root_in;
   end

   assign rsp_root = out_root_ff;

endmodule
`default_nettype wire

// File: rtl/drsqrt_checker.sv
// Port-level checker for the square root block, bound to the top level.
`default_nettype none
module drsqrt_checker (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  req_valid,
   input wire logic                                  req_stall,
   input wire logic                                  rsp_valid,
   input wire logic                                  rsp_stall,
   input wire logic [drsqrt_pkg::ROOT_WIDTH-1:0]     rsp_root
);
   import drsqrt_pkg::*;

   // a word held back by stall stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_root))
      else $error("rsp_root changed while stalled");

   // block is busy on the word it has just taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("new word taken during computation");

   // a result never appears the cycle after a word is taken
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result raised too early");

endmodule

bind digit_recurrence_square_root drsqrt_checker u_drsqrt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_root  (rsp_root)
);
`default_nettype wire

// File: sim/root_checker.sv
// Checker for the square root block: predicts every root and compares it with the response.
module root_checker (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   input  wire logic                                  req_stall,
   input  wire logic [drsqrt_pkg::RADICAND_WIDTH-1:0] req_radicand,
   input  wire logic [drsqrt_pkg::SETTING_WIDTH-1:0]  req_iteration_setting,
   input  wire logic                                  rsp_valid,
   input  wire logic                                  rsp_stall,
   input  wire logic [drsqrt_pkg::ROOT_WIDTH-1:0]     rsp_root,
   output int                                         failures,
   output int                                         roots_pending
);
   import drsqrt_pkg::*;

   typedef struct {
      logic [RADICAND_WIDTH-1:0] radicand;
      logic [SETTING_WIDTH-1:0]  setting;
      logic [ROOT_WIDTH-1:0]     root;
   } root_job_type;

   root_job_type expected_roots[$];

   // floor(sqrt(radicand * 4^k)), one root bit per step, remainder kept wide
   function automatic logic [ROOT_WIDTH-1:0] scaled_isqrt(
      input logic [RADICAND_WIDTH-1:0] radicand,
      input logic [SETTING_WIDTH-1:0]  setting
   );
      logic [RAD_PAD_WIDTH-1:0] padded;
      logic [63:0]              root;
      logic [63:0]              rem;
      logic [63:0]              trial;
      logic [1:0]               pair;
      int                       k;
      int                       total;
      int                       pos;
      int                       step;
      k = int'(setting >> 1);
      if (k > MAX_EXTRA_STEPS) k = MAX_EXTRA_STEPS;
      padded = RAD_PAD_WIDTH'(radicand);
      root   = '0;
      rem    = '0;
      total  = DIGIT_PAIRS + k;
      for (step = 0; step < total; step++) begin
         pos  = total - 1 - step;
         // radicand pairs first, then k pairs of zeros
         pair = (pos >= k) ? padded[2*(pos-k) +: 2] : 2'b00;
         rem   = {rem[61:0], pair};
         root  = root << 1;
         trial = {root[62:0], 1'b1};
         if (rem >= trial) begin
            rem     = rem - trial;
            root[0] = 1'b1;
         end
      end
      return root[ROOT_WIDTH-1:0];
   endfunction

   task automatic report_mismatch(input string what, input root_job_type job,
                                  input logic [ROOT_WIDTH-1:0] got);
      $display("root_checker: %s: radicand %h setting %0d got %h expected %h",
               what, job.radicand, job.setting, got, job.root);
      failures++;
   endtask

   initial begin
      failures      = 0;
      roots_pending = 0;
   end

   always @(posedge clock) begin
      root_job_type job;
      root_job_type none;
      none = '{default: '0};
      if (!reset) begin
         // response first: it can only belong to an earlier word
         if (rsp_valid && !rsp_stall) begin
            if (expected_roots.size() == 0) begin
               report_mismatch("unexpected root", none, rsp_root);
            end else begin
               job = expected_roots.pop_front();
               if (rsp_root !== job.root) report_mismatch("wrong root", job, rsp_root);
            end
         end
         if (req_valid && !req_stall) begin
            job.radicand = req_radicand;
            job.setting  = req_iteration_setting;
            job.root     = scaled_isqrt(req_radicand, req_iteration_setting);
            expected_roots.push_back(job);
         end
         roots_pending = expected_roots.size();
      end
   end

endmodule

// File: sim/testbench.sv
// Top of the square root testbench: clock, reset, word stimulus, response stalls and verdict.
module testbench;
   import drsqrt_pkg::*;

   localparam int RANDOM_WORDS = 700;
   localparam int CALM_WORDS   = 100;      // tail of the run with no idling on either side
   localparam int HOLD_AT      = 60;       // words sent before the long response hold-off
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 64;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DIRECTED     = 24;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [RADICAND_WIDTH-1:0] req_radicand;
   logic [SETTING_WIDTH-1:0]  req_iteration_setting;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [ROOT_WIDTH-1:0]     rsp_root;

   int failures;
   int roots_pending;
   int words_sent;
   int cycles;
   bit calm;       // set by the sender for the final stretch; the receiver follows it
   bit held;

   // directed words: zero, tiny values, the top of the range, perfect squares and
   // their neighbours, odd settings that must match the even one below, and the
   // largest settings where k reaches its ceiling of fifteen
   logic [RADICAND_WIDTH-1:0] dir_radicand [DIRECTED] = '{
      32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
      32'h0000_0004, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFE_0001,
      32'hFFFE_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      32'hFFFF_FFFF, 32'h0001_0000, 32'h0001_0000, 32'h0000_0002,
      32'h0000_0002, 32'h0000_0002, 32'h0000_0000, 32'h0000_0001,
      32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0003
   };
   logic [SETTING_WIDTH-1:0] dir_setting [DIRECTED] = '{
      5'd0,  5'd0,  5'd0,  5'd0,
      5'd0,  5'd0,  5'd0,  5'd0,
      5'd0,  5'd0,  5'd30, 5'd31,
      5'd16, 5'd16, 5'd17, 5'd1,
      5'd2,  5'd3,  5'd31, 5'd31,
      5'd29, 5'd5,  5'd10, 5'd31
   };

   digit_recurrence_square_root uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_radicand          (req_radicand),
      .req_iteration_setting (req_iteration_setting),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_root              (rsp_root)
   );

   root_checker u_root_checker (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_radicand          (req_radicand),
      .req_iteration_setting (req_iteration_setting),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_root              (rsp_root),
      .failures              (failures),
      .roots_pending         (roots_pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog: a hang anywhere ends the run as a failure
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d roots outstanding", cycles, roots_pending);
            $display("testbench: FAIL");
            $finish;
         end
      end
   end

   // Radicands: a quarter each of full-range, small, around perfect squares
   // (to hit both sides of every root step) and just below the top of the range.
   function automatic logic [RADICAND_WIDTH-1:0] pick_radicand();
      logic [RADICAND_WIDTH-1:0] base;
      int unsigned               mode;
      mode = $urandom_range(0, 3);
      case (mode)
         0: begin
            return $urandom;
         end
         1: begin
            return RADICAND_WIDTH'($urandom_range(0, 1023));
         end
         2: begin
            base = RADICAND_WIDTH'($urandom_range(0, 65535));
            return base * base + RADICAND_WIDTH'($urandom_range(0, 2)) - 1;
         end
         default: begin
            return 32'hFFFF_FFFF - RADICAND_WIDTH'($urandom_range(0, 4095));
         end
      endcase
   endfunction

   // Offers one word at the falling edge and holds it until it is taken.
   // Idle gaps come before roughly a quarter of the words, so
   // they land at random points of the block's work; runs without gaps occur too.
   // Returns at the falling edge after acceptance, so valid is touched once per step.
   task automatic offer_word(input logic [RADICAND_WIDTH-1:0] radicand,
                             input logic [SETTING_WIDTH-1:0]  setting);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_radicand          <= radicand;
      req_iteration_setting <= setting;
      req_valid             <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   // sender: reset, directed words, a full drain, random words, final drain, verdict
   initial begin
      int                       i;
      logic [SETTING_WIDTH-1:0] setting;
      reset                 = 1'b1;
      req_valid             = 1'b0;
      req_radicand          = '0;
      req_iteration_setting = '0;
      words_sent            = 0;
      calm                  = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (i = 0; i < DIRECTED; i++) offer_word(dir_radicand[i], dir_setting[i]);

      // stop offering until every root owed so far has come back
      req_valid <= 1'b0;
      while (roots_pending != 0) @(negedge clock);

      for (i = 0; i < RANDOM_WORDS; i++) begin
         if (i == RANDOM_WORDS - CALM_WORDS) calm = 1'b1;
         // lean a little on the plain and the 16.16 settings, the common uses
         case ($urandom_range(0, 7))
            0:       setting = 5'd0;
            1:       setting = 5'd16;
            default: setting = SETTING_WIDTH'($urandom_range(0, 31));
         endcase
         offer_word(pick_radicand(), setting);
      end
      req_valid <= 1'b0;

      while (roots_pending != 0) @(negedge clock);
      // room for any stray extra word to show up
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (failures == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   // Receiver: random bursts of stall and of free cycles. Once enough words
   // have gone in it holds off for a long stretch while the sender keeps
   // offering, so the output register and the datapath fill and req_stall rises.
   initial begin
      int len;
      rsp_stall = 1'b0;
      held      = 1'b0;
      @(negedge clock);
      forever begin
         if (calm) begin
            rsp_stall <= 1'b0;
            @(negedge clock);
         end else if (!held && words_sent >= HOLD_AT) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            len = $urandom_range(1, 16);
            rsp_stall <= ($urandom_range(0, 2) == 0);
            repeat (len) @(negedge clock);
         end
      end
   end

endmodule
